FILE: hw/rtl/sntp_rc_pkg.sv
// Package: item types, field positions, status codes and constants for the SNTP reply checker.
`timescale 1ns / 1ps

package sntp_rc_pkg;

  // Packet layout, byte positions within the reply
  localparam logic [5:0] PKT_BYTES  = 6'd48;
  localparam logic [5:0] HDR_POS    = 6'd0;
  localparam logic [5:0] STRAT_POS  = 6'd1;
  localparam logic [5:0] ORIG_FIRST = 6'd24;
  localparam logic [5:0] ORIG_LAST  = 6'd31;
  localparam logic [5:0] XMIT_FIRST = 6'd40;
  localparam logic [5:0] XMIT_LAST  = 6'd47;

  // Header decode
  localparam logic [2:0] MODE_SERVER = 3'd4;
  localparam logic [1:0] LI_UNSYNC   = 2'd3;
  localparam logic [7:0] STRATUM_MAX = 8'd15;

  // Time conversion
  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
  localparam logic [51:0] US_PER_SEC      = 52'd1000000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 1'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_SERV  = 3'd2,
    ST_BAD_STRAT = 3'd3,
    ST_UNSYNC    = 3'd4,
    ST_NONCE     = 3'd5,
    ST_ZERO_TIME = 3'd6,
    ST_PRE_1970  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        last_byte;
    logic [63:0] send_ticks;
    logic [63:0] receive_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [50:0] unix_us;
    logic [63:0] rtt_ticks;
    logic [63:0] mid_ticks;
  } out_item_t;

  // Classified packet handed from front to back
  typedef struct packed {
    status_t     status;
    logic [63:0] xmit_stamp;
    logic [63:0] send_ticks;
    logic [63:0] receive_ticks;
  } job_t;

  // Back stage 1: offset seconds, round trip
  typedef struct packed {
    status_t     status;
    logic [31:0] sec_off;
    logic [31:0] frac;
    logic [63:0] rtt;
    logic [63:0] send_ticks;
  } stage1_t;

  // Back stage 2: products, midpoint
  typedef struct packed {
    status_t     status;
    logic [51:0] us_sec;
    logic [19:0] us_frac;
    logic [63:0] rtt;
    logic [63:0] mid;
  } stage2_t;

endpackage

FILE: hw/rtl/sntp_rc_front.sv
// Front end: nonce registers, per-byte capture and packet classification.
`timescale 1ns / 1ps

module sntp_rc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  sntp_rc_pkg::in_item_t          in_item,
  input  logic                           cfg_fire,
  input  logic [sntp_rc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           push,
  output sntp_rc_pkg::job_t              job
);
  import sntp_rc_pkg::*;

  logic [31:0] nonce_high_r, nonce_high_nxt;
  logic [31:0] nonce_low_r, nonce_low_nxt;
  logic [5:0]  count_r, count_nxt, count_post;
  logic [7:0]  header_r, header_nxt, header_post;
  logic [7:0]  stratum_r, stratum_nxt, stratum_post;
  logic [63:0] orig_r, orig_nxt, orig_post;
  logic [63:0] xmit_r, xmit_nxt, xmit_post;
  logic [31:0] sec;
  status_t     status;

  // Configuration writes
  always_comb begin
    nonce_high_nxt = nonce_high_r;
    nonce_low_nxt  = nonce_low_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_NONCE_HIGH: nonce_high_nxt = cfg_data;
        REG_NONCE_LOW:  nonce_low_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // State after this byte is captured
  always_comb begin
    count_post   = count_r;
    header_post  = header_r;
    stratum_post = stratum_r;
    orig_post    = orig_r;
    xmit_post    = xmit_r;
    if (count_r < PKT_BYTES) begin
      count_post = count_r + 6'd1;
      if (count_r == HDR_POS) begin
        header_post = in_item.reply_byte;
      end else if (count_r == STRAT_POS) begin
        stratum_post = in_item.reply_byte;
      end else if (count_r >= ORIG_FIRST && count_r <= ORIG_LAST) begin
        orig_post = {orig_r[55:0], in_item.reply_byte};
      end else if (count_r >= XMIT_FIRST && count_r <= XMIT_LAST) begin
        xmit_post = {xmit_r[55:0], in_item.reply_byte};
      end
    end
  end

  // Checks in priority order
  assign sec = xmit_post[63:32];
  always_comb begin
    if (count_post < PKT_BYTES)                               status = ST_SHORT;
    else if (header_post[2:0] != MODE_SERVER)                 status = ST_NOT_SERV;
    else if (stratum_post == 8'd0 || stratum_post > STRATUM_MAX) status = ST_BAD_STRAT;
    else if (header_post[7:6] == LI_UNSYNC)                   status = ST_UNSYNC;
    else if (orig_post[63:32] != nonce_high_r ||
             orig_post[31:0] != nonce_low_r)                  status = ST_NONCE;
    else if (sec == 32'd0)                                    status = ST_ZERO_TIME;
    else if (sec < NTP_UNIX_OFFSET)                           status = ST_PRE_1970;
    else                                                      status = ST_OK;
  end

  always_comb begin
    count_nxt   = count_r;
    header_nxt  = header_r;
    stratum_nxt = stratum_r;
    orig_nxt    = orig_r;
    xmit_nxt    = xmit_r;
    if (in_fire) begin
      count_nxt   = in_item.last_byte ? 6'd0 : count_post;
      header_nxt  = header_post;
      stratum_nxt = stratum_post;
      orig_nxt    = orig_post;
      xmit_nxt    = xmit_post;
    end
  end

  // One job per packet, on its last byte
  assign push              = in_fire && in_item.last_byte;
  assign job.status        = status;
  assign job.xmit_stamp    = xmit_post;
  assign job.send_ticks    = in_item.send_ticks;
  assign job.receive_ticks = in_item.receive_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_high_r <= '0;
      nonce_low_r  <= '0;
      count_r      <= '0;
      header_r     <= '0;
      stratum_r    <= '0;
      orig_r       <= '0;
      xmit_r       <= '0;
    end else begin
      nonce_high_r <= nonce_high_nxt;
      nonce_low_r  <= nonce_low_nxt;
      count_r      <= count_nxt;
      header_r     <= header_nxt;
      stratum_r    <= stratum_nxt;
      orig_r       <= orig_nxt;
      xmit_r       <= xmit_nxt;
    end
  end

endmodule

FILE: hw/rtl/sntp_rc_fifo.sv
// Two-entry job queue between front and back.
`timescale 1ns / 1ps

module sntp_rc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sntp_rc_pkg::job_t  push_job,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output sntp_rc_pkg::job_t  head_job
);
  import sntp_rc_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/sntp_rc_back.sv
// Back end: three-stage time conversion and round-trip pipeline with output register.
`timescale 1ns / 1ps

module sntp_rc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  sntp_rc_pkg::job_t      job,
  output logic                   job_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sntp_rc_pkg::out_item_t out_item
);
  import sntp_rc_pkg::*;

  stage1_t   s1_r, s1_nxt;
  stage2_t   s2_r, s2_nxt;
  out_item_t s3_r, s3_nxt;
  logic      v1_r, v2_r, v3_r;
  logic      rdy1, rdy2, rdy3;
  logic [51:0] frac_prod;
  logic [51:0] us_sum;

  // Stage moves when its successor is empty or moving
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign job_ready = rdy1;

  // Stage 1: seconds since 1970, round trip
  always_comb begin
    s1_nxt.status     = job.status;
    s1_nxt.sec_off    = job.xmit_stamp[63:32] - NTP_UNIX_OFFSET;
    s1_nxt.frac       = job.xmit_stamp[31:0];
    s1_nxt.rtt        = job.receive_ticks - job.send_ticks;
    s1_nxt.send_ticks = job.send_ticks;
  end

  // Stage 2: scale to microseconds, midpoint
  assign frac_prod = {20'd0, s1_r.frac} * US_PER_SEC;
  always_comb begin
    s2_nxt.status  = s1_r.status;
    s2_nxt.us_sec  = {20'd0, s1_r.sec_off} * US_PER_SEC;
    s2_nxt.us_frac = frac_prod[51:32];
    s2_nxt.rtt     = s1_r.rtt;
    s2_nxt.mid     = s1_r.send_ticks + {1'b0, s1_r.rtt[63:1]};
  end

  // Stage 3: sum, zero on any failed check
  assign us_sum = s2_r.us_sec + {32'd0, s2_r.us_frac};
  always_comb begin
    s3_nxt.status    = s2_r.status;
    s3_nxt.unix_us   = (s2_r.status == ST_OK) ? us_sum[50:0] : 51'd0;
    s3_nxt.rtt_ticks = s2_r.rtt;
    s3_nxt.mid_ticks = s2_r.mid;
  end

  assign out_valid = v3_r;
  assign out_item  = s3_r;

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= job_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

endmodule

FILE: hw/rtl/sntp_rc_top_dummy_unused.sv
// Configuration write port: always ready, passes the register index on with the write strobe.
`timescale 1ns / 1ps

module sntp_rc_cfg_port (
  input  logic                              cfg_valid,
  input  logic [sntp_rc_pkg::CFG_IDX_W-1:0] cfg_index,
  output logic                              cfg_ready,
  output logic                              cfg_fire,
  output logic [sntp_rc_pkg::CFG_IDX_W-1:0] cfg_sel
);
  import sntp_rc_pkg::*;

  // Writes are always taken; the index is passed on with the strobe
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign cfg_sel   = cfg_index;

endmodule

FILE: hw/rtl/sntp_reply_check_convert.sv
// Top level: SNTP reply checker and time converter.
//
// Usage:
//   in_*  : one reply byte per item with last_byte marking the final byte;
//           send_ticks and receive_ticks are used on the last byte only.
//   out_* : one result per packet (status, unix_us, rtt_ticks, mid_ticks).
//   cfg_* : register writes, index 0 nonce_high, index 1 nonce_low; always ready.
// Throughput: one input item per cycle while in_ready is high. The front
//   registers each byte as it is accepted; a two-entry queue feeds a
//   three-stage back pipeline whose longest step is one 32x20 multiply.
// Path: after the edge that accepts its last byte, a packet's job waits in a
//   queue slot, then passes through stages 1, 2 and 3 to out_valid.
// Stall: when out_ready is low the pipeline fills, then the queue; in_ready
//   drops only when the queue holds two packets. Bytes that do not end a
//   packet only need in_ready.
// Reset: synchronous, active low; clears the byte count, captured fields,
//   nonce registers and all valid bits. No clearing pass is needed.
`timescale 1ns / 1ps

module sntp_reply_check_convert (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sntp_rc_pkg::in_item_t             in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sntp_rc_pkg::out_item_t            out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sntp_rc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);
  import sntp_rc_pkg::*;

  logic                 in_fire;
  logic                 cfg_fire;
  logic [CFG_IDX_W-1:0] cfg_sel;
  logic                 push;
  job_t                 push_job;
  logic                 q_full;
  logic                 q_not_empty;
  job_t                 head_job;
  logic                 back_ready;
  logic                 pop;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign pop      = q_not_empty && back_ready;

  sntp_rc_cfg_port u_cfg (
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_ready (cfg_ready),
    .cfg_fire  (cfg_fire),
    .cfg_sel   (cfg_sel)
  );

  sntp_rc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_sel),
    .cfg_data  (cfg_data),
    .push      (push),
    .job       (push_job)
  );

  sntp_rc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  sntp_rc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (head_job),
    .job_ready (back_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: sim/tb_sntp_reply_check_convert.sv
// Testbench: random and directed NTP reply packets against a cycle-free predictor of the checker.
`timescale 1ns / 1ps

module tb_sntp_reply_check_convert;
  import sntp_rc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PKT_MAX      = 72;
  localparam int PHASE_ITEMS  = 150;
  localparam int PHASE_RESULTS = 3;

  // Predicts one result per packet and checks what the block returns
  class reply_tracker;
    logic [31:0] nonce_high;
    logic [31:0] nonce_low;
    logic [5:0]  byte_pos;
    logic [7:0]  header;
    logic [7:0]  stratum;
    logic [63:0] orig_stamp;
    logic [63:0] xmit_stamp;
    out_item_t   due_results[$];
    int          errors;
    int          results_seen;

    function new();
      nonce_high   = '0;
      nonce_low    = '0;
      byte_pos     = '0;
      header       = '0;
      stratum      = '0;
      orig_stamp   = '0;
      xmit_stamp   = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_nonce(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_NONCE_HIGH: nonce_high = data;
        REG_NONCE_LOW:  nonce_low  = data;
        default: ;
      endcase
    endfunction

    // Checks in priority order, first failing one wins
    function status_t classify();
      if (byte_pos < PKT_BYTES) return ST_SHORT;
      if (header[2:0] != MODE_SERVER) return ST_NOT_SERV;
      if (stratum == 8'd0 || stratum > STRATUM_MAX) return ST_BAD_STRAT;
      if (header[7:6] == LI_UNSYNC) return ST_UNSYNC;
      if (orig_stamp != {nonce_high, nonce_low}) return ST_NONCE;
      if (xmit_stamp[63:32] == 32'd0) return ST_ZERO_TIME;
      if (xmit_stamp[63:32] < NTP_UNIX_OFFSET) return ST_PRE_1970;
      return ST_OK;
    endfunction

    function void take_byte(in_item_t it);
      out_item_t   want;
      status_t     st;
      logic [63:0] sec;
      logic [63:0] frac;
      logic [63:0] us;
      logic [63:0] rtt;
      // capture, counter saturates at a full packet
      if (byte_pos < PKT_BYTES) begin
        if (byte_pos == HDR_POS) begin
          header = it.reply_byte;
        end else if (byte_pos == STRAT_POS) begin
          stratum = it.reply_byte;
        end else if (byte_pos >= ORIG_FIRST && byte_pos <= ORIG_LAST) begin
          orig_stamp = {orig_stamp[55:0], it.reply_byte};
        end else if (byte_pos >= XMIT_FIRST && byte_pos <= XMIT_LAST) begin
          xmit_stamp = {xmit_stamp[55:0], it.reply_byte};
        end
        byte_pos = byte_pos + 6'd1;
      end
      if (!it.last_byte) return;

      st = classify();
      us = '0;
      if (st == ST_OK) begin
        sec  = {32'd0, xmit_stamp[63:32]};
        frac = {32'd0, xmit_stamp[31:0]};
        us = (sec - 64'(NTP_UNIX_OFFSET)) * 64'(US_PER_SEC)
           + ((frac * 64'(US_PER_SEC)) >> 32);
      end
      rtt = it.receive_ticks - it.send_ticks;
      want.status    = st;
      want.unix_us   = us[50:0];
      want.rtt_ticks = rtt;
      want.mid_ticks = it.send_ticks + (rtt >> 1);
      due_results.push_back(want);
      byte_pos = '0;
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result with no packet pending: status %0d", got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.unix_us !== want.unix_us) begin
        $error("unix_us: expected %0d, actual %0d", want.unix_us, got.unix_us);
        errors++;
      end
      if (got.rtt_ticks !== want.rtt_ticks) begin
        $error("rtt_ticks: expected %h, actual %h", want.rtt_ticks, got.rtt_ticks);
        errors++;
      end
      if (got.mid_ticks !== want.mid_ticks) begin
        $error("mid_ticks: expected %h, actual %h", want.mid_ticks, got.mid_ticks);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_item   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  out_item_t            out_item;

  reply_tracker trk;
  logic [7:0]   pkt [0:PKT_MAX-1];
  int           burst_left  = 0;
  int           items_done  = 0;
  int           cycle_count = 0;
  int           rx_cycle    = 0;
  int           rx_hold     = 0;

  sntp_reply_check_convert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: check accepted results, ready follows a rotating stall pattern
  always @(posedge clk) begin
    logic ready_next;
    if (rst_n && out_valid && out_ready) trk.match_result(out_item);
    rx_cycle++;
    case ((rx_cycle / 300) % 4)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 3) != 0);
      2: ready_next = (rx_cycle % 7 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(5, 25);
        end
      end
    endcase
    out_ready <= ready_next;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void put_stamp(int pos, logic [63:0] v);
    for (int k = 0; k < 8; k++) pkt[pos + k] = v[63 - 8 * k -: 8];
  endfunction

  // Well-formed packet with random filler, matching the current nonce
  function automatic void fill_good(logic [31:0] sec, logic [31:0] frac);
    for (int i = 0; i < PKT_MAX; i++) pkt[i] = 8'($urandom);
    pkt[HDR_POS]   = {2'($urandom_range(0, 2)), 3'($urandom), MODE_SERVER};
    pkt[STRAT_POS] = 8'($urandom_range(1, STRATUM_MAX));
    put_stamp(ORIG_FIRST, {trk.nonce_high, trk.nonce_low});
    put_stamp(XMIT_FIRST, {sec, frac});
  endfunction

  // One input item; sender runs in bursts with random gaps
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    trk.take_byte(it);
    burst_left--;
  endtask

  task automatic push_packet(int len, logic [63:0] t_send, logic [63:0] t_recv);
    in_item_t it;
    bit       last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      it.reply_byte    = pkt[i];
      it.last_byte     = last;
      it.send_ticks    = last ? t_send : rand64();
      it.receive_ticks = last ? t_recv : rand64();
      send_item(it);
      items_done++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trk.set_nonce(idx, data);
    @(posedge clk);
  endtask

  // Drain all pending results, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (trk.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // extremes of time and ticks
    fill_good(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_packet(PKT_BYTES, 64'd0, '1);
    fill_good(NTP_UNIX_OFFSET, 32'd0);
    push_packet(PKT_BYTES, '1, 64'd0);
    // top stratum, leap indicator 2
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[HDR_POS]   = {2'd2, 3'd2, MODE_SERVER};
    pkt[STRAT_POS] = STRATUM_MAX;
    push_packet(PKT_BYTES, rand64(), rand64());
    // short and long packets
    push_packet(1, rand64(), rand64());
    push_packet(PKT_BYTES - 1, rand64(), rand64());
    push_packet(PKT_MAX, rand64(), rand64());
    // mode not server
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[HDR_POS] = {2'd0, 3'd4, 3'd5};
    push_packet(PKT_BYTES, rand64(), rand64());
    // every fault at once: mode takes priority
    fill_good(32'd0, 32'd0);
    pkt[HDR_POS]   = {LI_UNSYNC, 3'd4, 3'd3};
    pkt[STRAT_POS] = 8'd0;
    pkt[ORIG_FIRST] = pkt[ORIG_FIRST] ^ 8'h01;
    push_packet(PKT_BYTES, rand64(), rand64());
    // stratum zero and above the limit
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[STRAT_POS] = 8'd0;
    push_packet(PKT_BYTES, rand64(), rand64());
    pkt[STRAT_POS] = STRATUM_MAX + 8'd1;
    push_packet(PKT_BYTES, rand64(), rand64());
    // unsynchronized server
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[HDR_POS] = {LI_UNSYNC, 3'd4, MODE_SERVER};
    push_packet(PKT_BYTES, rand64(), rand64());
    // nonce mismatch in the high and in the low word
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[ORIG_FIRST] = pkt[ORIG_FIRST] ^ 8'h80;
    push_packet(PKT_BYTES, rand64(), rand64());
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    pkt[ORIG_LAST] = pkt[ORIG_LAST] ^ 8'h01;
    push_packet(PKT_BYTES, rand64(), rand64());
    // zero seconds, and seconds just before and well before 1970
    fill_good(32'd0, 32'hFFFF_FFFF);
    push_packet(PKT_BYTES, rand64(), rand64());
    fill_good(NTP_UNIX_OFFSET - 32'd1, 32'hFFFF_FFFF);
    push_packet(PKT_BYTES, rand64(), rand64());
    fill_good(32'd1, 32'd0);
    push_packet(PKT_BYTES, rand64(), rand64());
  endtask

  task automatic send_random_packet();
    int          kind;
    int          len;
    int          pos;
    int          bit_idx;
    int          m;
    logic [63:0] t_send;
    logic [63:0] t_recv;
    kind = $urandom_range(0, 99);
    fill_good($urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET), $urandom);
    t_send = rand64();
    case ($urandom_range(0, 2))
      0: t_recv = rand64();
      1: t_recv = t_send + 64'($urandom_range(0, 5000));
      default: t_recv = t_send - 64'($urandom_range(1, 5000));
    endcase
    len = PKT_BYTES;
    if (kind < 10) begin
      // pure noise of any length
      for (int i = 0; i < PKT_MAX; i++) pkt[i] = 8'($urandom);
      len = $urandom_range(1, PKT_MAX);
    end else if (kind < 20) begin
      len = $urandom_range(1, PKT_BYTES - 1);
    end else if (kind < 28) begin
      len = $urandom_range(PKT_BYTES + 1, PKT_MAX);
    end else begin
      // full packet with independent random faults
      if ($urandom_range(0, 9) == 0) begin
        m = $urandom_range(0, 6);
        if (m >= MODE_SERVER) m++;
        pkt[HDR_POS][2:0] = 3'(m);
      end
      if ($urandom_range(0, 9) == 0)
        pkt[STRAT_POS] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(16, 255));
      if ($urandom_range(0, 9) == 0) pkt[HDR_POS][7:6] = LI_UNSYNC;
      if ($urandom_range(0, 9) == 0) begin
        pos     = ORIG_FIRST + $urandom_range(0, 7);
        bit_idx = $urandom_range(0, 7);
        pkt[pos][bit_idx] = ~pkt[pos][bit_idx];
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) put_stamp(XMIT_FIRST, {32'd0, 32'($urandom)});
        else put_stamp(XMIT_FIRST, {32'($urandom_range(1, NTP_UNIX_OFFSET - 1)),
                                    32'($urandom)});
      end
    end
    push_packet(len, t_send, t_recv);
  endtask

  initial begin
    int item_goal;
    int result_goal;
    trk = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Each setting: write both nonce words, run packets, drain
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin
          write_reg(REG_NONCE_HIGH, $urandom);
          write_reg(REG_NONCE_LOW, $urandom);
        end
        1: begin
          write_reg(REG_NONCE_HIGH, 32'd0);
          write_reg(REG_NONCE_LOW, 32'd0);
        end
        2: begin
          write_reg(REG_NONCE_HIGH, 32'hFFFF_FFFF);
          write_reg(REG_NONCE_LOW, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_NONCE_HIGH, 32'hFFFF_FFFF);
          write_reg(REG_NONCE_LOW, 32'd0);
        end
        default: begin
          write_reg(REG_NONCE_HIGH, 32'd0);
          write_reg(REG_NONCE_LOW, 32'hFFFF_FFFF);
        end
      endcase
      if (k == 0) run_directed();
      item_goal   = items_done + PHASE_ITEMS;
      result_goal = trk.results_seen + PHASE_RESULTS;
      while (items_done < item_goal || trk.results_seen < result_goal)
        send_random_packet();
      settle();
    end

    if (trk.errors == 0 && trk.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
